// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the gain-scheduled PID block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond implies prop in the same cycle
`define ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// cond implies prop in the next cycle
`define ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(name, cond, prop)
`define ASSERT_NXT(name, cond, prop)
`endif
`endif

// ===== rtl/gsp_pkg.sv =====
// Types, codes and helper functions of the gain-scheduled PID block
`default_nettype none
package gsp_pkg;

  localparam int TABLE_POINTS_DEF = 8;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int DATA_W           = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int OP_W             = 33;
  localparam int WIDE_W           = 66;
  localparam int ALPHA_BITS       = 16;
  localparam int ALPHA_W          = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_STEP_DONE  = 2'd0,
    ST_STORED     = 2'd1,
    ST_FULL       = 2'd2,
    ST_RESET_DONE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFT_MODE  = 3'd0,
    REG_DERIV_FB   = 3'd1,
    REG_PERIOD     = 3'd2,
    REG_INV_PERIOD = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_OUT_MIN    = 3'd5,
    REG_INT_LIMIT  = 3'd6,
    REG_ALPHA      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                     soft_mode;
    logic                     deriv_on_fb;
    logic [30:0]              sample_period;
    logic [30:0]              inv_period;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic [30:0]              int_limit;
    logic [ALPHA_W-1:0]       alpha;
  } cfg_t;

  // One table row
  typedef struct packed {
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
  } row_t;

  typedef enum logic [3:0] {
    MS_KP_ERR, MS_ERR_DT, MS_DIFF_INV, MS_KI_ACC, MS_A_DIN,
    MS_NA_DF, MS_KD_DF, MS_T_DKP, MS_T_DKI, MS_T_DKD
  } mul_sel_t;

  typedef enum logic [3:0] {
    CM_NONE, CM_PTERM, CM_ISTEP, CM_DIN, CM_ITERM, CM_FSUM,
    CM_DF, CM_DTERM, CM_GP, CM_GI, CM_GD
  } commit_t;

  typedef enum logic [1:0] {
    GS_HOLD, GS_ZERO, GS_A, GS_B
  } gain_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      capture;
    logic      tbl_wr;
    logic      rd_en;
    gain_sel_t gain_sel;
    logic      div_init;
    logic      div_step;
    logic      err_calc;
    mul_sel_t  mul_sel;
    commit_t   commit;
    logic      clr_dyn;
    logic      finish;
    logic      out_ld;
    status_t   out_status;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  le_a;
    logic  ge_b;
    logic  in_ab;
  } dp_stat_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (&x[WIDE_W-1:DATA_W-1] || ~|x[WIDE_W-1:DATA_W-1]) begin
      r = x[DATA_W-1:0];
    end else if (x[WIDE_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gsp_if.sv =====
// Valid/ready channel interfaces for input items and results
`default_nettype none
interface gsp_in_if;
  import gsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] feedback;
  logic signed [DATA_W-1:0] sched_value;
  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] gain_d;
  modport source (output valid, kind, setpoint, feedback, sched_value, gain_p, gain_i,
                  gain_d, input ready);
  modport sink (input valid, kind, setpoint, feedback, sched_value, gain_p, gain_i,
                gain_d, output ready);
endinterface

interface gsp_out_if;
  import gsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] control_out;
  logic                     saturated;
  logic signed [DATA_W-1:0] active_kp;
  logic signed [DATA_W-1:0] active_ki;
  logic signed [DATA_W-1:0] active_kd;
  modport source (output valid, status, control_out, saturated, active_kp, active_ki,
                  active_kd, input ready);
  modport sink (input valid, status, control_out, saturated, active_kp, active_ki,
                active_kd, output ready);
endinterface
`default_nettype wire

// ===== rtl/gsp_cfg.sv =====
// Configuration register file
`default_nettype none
module gsp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsp_pkg::DATA_W-1:0]    cfg_data,
  output gsp_pkg::cfg_t                 cfg
);
  import gsp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SOFT_MODE:  cfg_nxt.soft_mode     = cfg_data[0];
        REG_DERIV_FB:   cfg_nxt.deriv_on_fb   = cfg_data[0];
        REG_PERIOD:     cfg_nxt.sample_period = cfg_data[30:0];
        REG_INV_PERIOD: cfg_nxt.inv_period    = cfg_data[30:0];
        REG_OUT_MAX:    cfg_nxt.out_max       = cfg_data;
        REG_OUT_MIN:    cfg_nxt.out_min       = cfg_data;
        REG_INT_LIMIT:  cfg_nxt.int_limit     = cfg_data[30:0];
        REG_ALPHA:      cfg_nxt.alpha         = cfg_data[ALPHA_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_mode     <= 1'b0;
      cfg_r.deriv_on_fb   <= 1'b0;
      cfg_r.sample_period <= 31'd65536;
      cfg_r.inv_period    <= 31'd65536;
      cfg_r.out_max       <= '0;
      cfg_r.out_min       <= '0;
      cfg_r.int_limit     <= 31'h7fff_ffff;
      cfg_r.alpha         <= 17'd6554;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ===== rtl/gsp_ctrl.sv =====
// Sequencer: table scan, interpolation divide, the PID multiply schedule, loads and resets
`default_nettype none
module gsp_ctrl #(
  parameter int TABLE_POINTS = gsp_pkg::TABLE_POINTS_DEF,
  parameter int FRAC_BITS    = gsp_pkg::FRAC_BITS_DEF,
  localparam int AW = $clog2(TABLE_POINTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               soft_mode,
  input  gsp_pkg::dp_stat_t  stat,
  output gsp_pkg::dp_cmd_t   cmd,
  output logic [AW-1:0]      rd_addr_a,
  output logic [AW-1:0]      rd_addr_b,
  output logic [AW-1:0]      wr_addr
);
  import gsp_pkg::*;

  localparam int CW  = $clog2(TABLE_POINTS + 1);
  localparam int DCW = $clog2(FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ENDS_RD, S_ENDS_CK, S_SCAN_CK, S_LAST_CK, S_DIV,
    S_I1, S_I2, S_I3, S_I4, S_ERR, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_M7, S_M8, S_M9, S_M10, S_LOAD, S_RST
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;
  logic           full;
  logic [CW-1:0]  last_w;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (cnt_r == CW'(TABLE_POINTS));
  assign last_w   = cnt_r - CW'(1);

  // Next-state and command decode
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    dcnt_nxt      = dcnt_r;
    cmd           = '0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_STEP: begin
            if (cnt_r == '0) begin
              cmd.gain_sel = GS_ZERO;
              state_nxt    = S_ERR;
            end else begin
              state_nxt = S_ENDS_RD;
            end
          end
          KIND_LOAD:  state_nxt = S_LOAD;
          KIND_RESET: state_nxt = S_RST;
          KIND_NONE:  state_nxt = S_IDLE;
          default:    state_nxt = S_IDLE;
        endcase
      end
      // fetch first and last points
      S_ENDS_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr_b = last_w[AW-1:0];
        state_nxt = S_ENDS_CK;
      end
      S_ENDS_CK: begin
        priority if (stat.le_a) begin
          cmd.gain_sel = GS_A;
          state_nxt    = S_ERR;
        end else if (stat.ge_b) begin
          cmd.gain_sel = GS_B;
          state_nxt    = S_ERR;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr_b = AW'(1);
          idx_nxt   = '0;
          state_nxt = S_SCAN_CK;
        end
      end
      // one interval per check
      S_SCAN_CK: begin
        priority if (stat.in_ab) begin
          if (soft_mode) begin
            cmd.div_init = 1'b1;
            dcnt_nxt     = '0;
            state_nxt    = S_DIV;
          end else begin
            cmd.gain_sel = GS_A;
            state_nxt    = S_ERR;
          end
        end else if (CW'(idx_r) + CW'(2) == cnt_r) begin
          cmd.rd_en = 1'b1;
          rd_addr_a = last_w[AW-1:0];
          rd_addr_b = last_w[AW-1:0];
          state_nxt = S_LAST_CK;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr_a = idx_r + AW'(1);
          rd_addr_b = idx_r + AW'(2);
          idx_nxt   = idx_r + AW'(1);
        end
      end
      S_LAST_CK: begin
        cmd.gain_sel = GS_A;
        state_nxt    = S_ERR;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(FRAC_BITS - 1)) begin
          state_nxt = S_I1;
        end
      end
      // interpolate the three gains
      S_I1: begin
        cmd.mul_sel = MS_T_DKP;
        state_nxt   = S_I2;
      end
      S_I2: begin
        cmd.commit  = CM_GP;
        cmd.mul_sel = MS_T_DKI;
        state_nxt   = S_I3;
      end
      S_I3: begin
        cmd.commit  = CM_GI;
        cmd.mul_sel = MS_T_DKD;
        state_nxt   = S_I4;
      end
      S_I4: begin
        cmd.commit = CM_GD;
        state_nxt  = S_ERR;
      end
      // PID terms through the shared multiplier
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_nxt    = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MS_KP_ERR;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.commit  = CM_PTERM;
        cmd.mul_sel = MS_ERR_DT;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.commit  = CM_ISTEP;
        cmd.mul_sel = MS_DIFF_INV;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.commit  = CM_DIN;
        cmd.mul_sel = MS_KI_ACC;
        state_nxt   = S_M5;
      end
      S_M5: begin
        cmd.commit  = CM_ITERM;
        cmd.mul_sel = MS_A_DIN;
        state_nxt   = S_M6;
      end
      S_M6: begin
        cmd.commit  = CM_FSUM;
        cmd.mul_sel = MS_NA_DF;
        state_nxt   = S_M7;
      end
      S_M7: begin
        cmd.commit = CM_DF;
        state_nxt  = S_M8;
      end
      S_M8: begin
        cmd.mul_sel = MS_KD_DF;
        state_nxt   = S_M9;
      end
      S_M9: begin
        cmd.commit = CM_DTERM;
        state_nxt  = S_M10;
      end
      S_M10: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          cmd.out_ld     = 1'b1;
          cmd.out_status = ST_STEP_DONE;
          state_nxt      = S_IDLE;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          if (full) begin
            cmd.out_status = ST_FULL;
          end else begin
            cmd.tbl_wr     = 1'b1;
            cmd.out_status = ST_STORED;
            cnt_nxt        = cnt_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_RST: begin
        if (out_free) begin
          cmd.clr_dyn    = 1'b1;
          cmd.out_ld     = 1'b1;
          cmd.out_status = ST_RESET_DONE;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_ld || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign wr_addr   = cnt_r[AW-1:0];

`include "assert_macros.svh"
  `ASSERT_IMP(a_no_overwrite, cmd.out_ld, out_free)
  `ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(TABLE_POINTS))
  `ASSERT_NXT(a_wr_count, cmd.tbl_wr, cnt_r == $past(cnt_r) + CW'(1))
endmodule
`default_nettype wire

// ===== rtl/gsp_dp.sv =====
// Datapath: point table, divider, shared multiplier and PID state
`default_nettype none
module gsp_dp #(
  parameter int TABLE_POINTS = gsp_pkg::TABLE_POINTS_DEF,
  parameter int FRAC_BITS    = gsp_pkg::FRAC_BITS_DEF,
  localparam int AW = $clog2(TABLE_POINTS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gsp_pkg::cfg_t                    cfg,
  input  gsp_pkg::dp_cmd_t                 cmd,
  output gsp_pkg::dp_stat_t                stat,
  input  logic [AW-1:0]                    rd_addr_a,
  input  logic [AW-1:0]                    rd_addr_b,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [1:0]                       in_kind,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_setpoint,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_feedback,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_sched_value,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_gain_p,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_gain_i,
  input  logic signed [gsp_pkg::DATA_W-1:0] in_gain_d,
  output logic [1:0]                       out_status,
  output logic signed [gsp_pkg::DATA_W-1:0] out_control,
  output logic                             out_saturated,
  output logic signed [gsp_pkg::DATA_W-1:0] out_kp,
  output logic signed [gsp_pkg::DATA_W-1:0] out_ki,
  output logic signed [gsp_pkg::DATA_W-1:0] out_kd
);
  import gsp_pkg::*;

  // captured item
  kind_t                    kind_r;
  logic signed [DATA_W-1:0] sp_r, fb_r, sv_r, gp_in_r, gi_in_r, gd_in_r;
  // table
  row_t                     tbl_mem [TABLE_POINTS];
  row_t                     rowa_r, rowb_r;
  // divider
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        den_r;
  logic [FRAC_BITS-1:0]     q_r;
  // gains and dynamic state
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r;
  logic signed [DATA_W-1:0] acc_r, prev_err_r, prev_fb_r, df_r;
  // step temporaries
  logic signed [DATA_W-1:0] err_r, diff_r, pterm_r, iterm_r, dterm_r, din_r;
  logic signed [WIDE_W-1:0] istep_r, fsum_r, prod_r;
  logic [ALPHA_W-1:0]       a_r;
  // output register
  status_t                  ostat_r;
  logic signed [DATA_W-1:0] octrl_r;
  logic                     osat_r;
  logic signed [DATA_W-1:0] okp_r, oki_r, okd_r;

  logic signed [OP_W-1:0]   op_a, op_b, t_ext, lim_op;
  logic signed [WIDE_W-1:0] prod_sh, acc_sum, lim_w, acc_cl, undo, fdf;
  logic signed [DATA_W-1:0] err_c, diff_c;
  logic signed [DATA_W+1:0] u_sum, u_cl;
  logic                     sat_c;
  logic [DATA_W:0]          rem_sh;

  assign t_ext   = $signed({{(OP_W-FRAC_BITS){1'b0}}, q_r});
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign lim_op  = $signed({2'b00, cfg.int_limit});

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MS_KP_ERR:   begin op_a = OP_W'(kp_r);  op_b = OP_W'(err_r); end
      MS_ERR_DT:   begin op_a = OP_W'(err_r); op_b = $signed({2'b00, cfg.sample_period}); end
      MS_DIFF_INV: begin op_a = OP_W'(diff_r); op_b = $signed({2'b00, cfg.inv_period}); end
      MS_KI_ACC:   begin op_a = OP_W'(ki_r);  op_b = OP_W'(acc_r); end
      MS_A_DIN:    begin op_a = $signed(OP_W'(a_r)); op_b = OP_W'(din_r); end
      MS_NA_DF:    begin op_a = $signed(OP_W'(ALPHA_ONE - a_r)); op_b = OP_W'(df_r); end
      MS_KD_DF:    begin op_a = OP_W'(kd_r);  op_b = OP_W'(df_r); end
      MS_T_DKP:    begin op_a = t_ext; op_b = OP_W'(rowb_r.kp) - OP_W'(rowa_r.kp); end
      MS_T_DKI:    begin op_a = t_ext; op_b = OP_W'(rowb_r.ki) - OP_W'(rowa_r.ki); end
      MS_T_DKD:    begin op_a = t_ext; op_b = OP_W'(rowb_r.kd) - OP_W'(rowa_r.kd); end
      default:     begin op_a = '0; op_b = '0; end
    endcase
  end

  // Error, difference, integral clamp, filter and output limit
  always_comb begin
    err_c   = sat32(WIDE_W'(sp_r) - WIDE_W'(fb_r));
    diff_c  = cfg.deriv_on_fb ? sat32(WIDE_W'(prev_fb_r) - WIDE_W'(fb_r))
                              : sat32(WIDE_W'(err_c) - WIDE_W'(prev_err_r));
    lim_w   = $signed(WIDE_W'(cfg.int_limit));
    acc_sum = WIDE_W'(acc_r) + prod_sh;
    acc_cl  = acc_sum;
    if (acc_cl > lim_w) acc_cl = lim_w;
    if (acc_cl < -lim_w) acc_cl = -lim_w;
    fdf     = (fsum_r + prod_r) >>> ALPHA_BITS;
    undo    = WIDE_W'(acc_r) - istep_r;
    u_sum   = (DATA_W+2)'(pterm_r) + (DATA_W+2)'(iterm_r) + (DATA_W+2)'(dterm_r);
    priority if (u_sum > (DATA_W+2)'(cfg.out_max)) u_cl = (DATA_W+2)'(cfg.out_max);
    else if (u_sum < (DATA_W+2)'(cfg.out_min)) u_cl = (DATA_W+2)'(cfg.out_min);
    else u_cl = u_sum;
    sat_c   = (u_cl >= (DATA_W+2)'(cfg.out_max)) || (u_cl <= (DATA_W+2)'(cfg.out_min));
    rem_sh  = {rem_r, 1'b0};
  end

  // Table memory, registered two-port read
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[wr_addr] <= '{pos: sv_r, kp: gp_in_r, ki: gi_in_r, kd: gd_in_r};
    end
    if (cmd.rd_en) begin
      rowa_r <= tbl_mem[rd_addr_a];
      rowb_r <= tbl_mem[rd_addr_b];
    end
  end

  // Payload and temporaries, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(in_kind);
      sp_r    <= in_setpoint;
      fb_r    <= in_feedback;
      sv_r    <= in_sched_value;
      gp_in_r <= in_gain_p;
      gi_in_r <= in_gain_i;
      gd_in_r <= in_gain_d;
    end
    // restoring divide, one quotient bit a cycle
    if (cmd.div_init) begin
      rem_r <= sv_r - rowa_r.pos;
      den_r <= rowb_r.pos - rowa_r.pos;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= DATA_W'(rem_sh - {1'b0, den_r});
        q_r   <= {q_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
        q_r   <= {q_r[FRAC_BITS-2:0], 1'b0};
      end
    end
    prod_r <= op_a * op_b;
    if (cmd.err_calc) begin
      err_r  <= err_c;
      diff_r <= diff_c;
      a_r    <= (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    end
    unique case (cmd.commit)
      CM_PTERM: pterm_r <= sat32(prod_sh);
      CM_ISTEP: istep_r <= prod_sh;
      CM_DIN:   din_r   <= sat32(prod_sh);
      CM_ITERM: iterm_r <= sat32(prod_sh);
      CM_FSUM:  fsum_r  <= prod_r;
      CM_DTERM: dterm_r <= sat32(prod_sh);
      default: ;
    endcase
    // result register, gains frozen with the rest of the transfer
    if (cmd.out_ld) begin
      ostat_r <= cmd.out_status;
      octrl_r <= cmd.finish ? u_cl[DATA_W-1:0] : '0;
      osat_r  <= cmd.finish ? sat_c : 1'b0;
      okp_r   <= kp_r;
      oki_r   <= ki_r;
      okd_r   <= kd_r;
    end
  end

  // Gains and dynamic state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      acc_r      <= '0;
      prev_err_r <= '0;
      prev_fb_r  <= '0;
      df_r       <= '0;
    end else begin
      unique case (cmd.gain_sel)
        GS_ZERO: begin kp_r <= '0; ki_r <= '0; kd_r <= '0; end
        GS_A:    begin kp_r <= rowa_r.kp; ki_r <= rowa_r.ki; kd_r <= rowa_r.kd; end
        GS_B:    begin kp_r <= rowb_r.kp; ki_r <= rowb_r.ki; kd_r <= rowb_r.kd; end
        default: ;
      endcase
      unique case (cmd.commit)
        CM_GP:    kp_r  <= rowa_r.kp + prod_sh[DATA_W-1:0];
        CM_GI:    ki_r  <= rowa_r.ki + prod_sh[DATA_W-1:0];
        CM_GD:    kd_r  <= rowa_r.kd + prod_sh[DATA_W-1:0];
        CM_ISTEP: acc_r <= acc_cl[DATA_W-1:0];
        CM_DF:    df_r  <= fdf[DATA_W-1:0];
        default: ;
      endcase
      if (cmd.finish) begin
        if (sat_c) acc_r <= sat32(undo);
        prev_err_r <= err_r;
        prev_fb_r  <= fb_r;
      end
      if (cmd.clr_dyn) begin
        acc_r      <= '0;
        prev_err_r <= '0;
        prev_fb_r  <= '0;
        df_r       <= '0;
      end
    end
  end

  assign stat.kind  = kind_r;
  assign stat.le_a  = (sv_r <= rowa_r.pos);
  assign stat.ge_b  = (sv_r >= rowb_r.pos);
  assign stat.in_ab = (sv_r >= rowa_r.pos) && (sv_r < rowb_r.pos);

  assign out_status    = ostat_r;
  assign out_control   = octrl_r;
  assign out_saturated = osat_r;
  assign out_kp        = okp_r;
  assign out_ki        = oki_r;
  assign out_kd        = okd_r;

`include "assert_macros.svh"
  `ASSERT_NXT(a_acc_clamp, cmd.commit == CM_ISTEP, (OP_W'(acc_r) <= lim_op) && (OP_W'(acc_r) >= -lim_op))
  `ASSERT_NXT(a_df_hold, (cmd.commit != CM_DF) && !cmd.clr_dyn, $stable(df_r))
  `ASSERT_NXT(a_rows_hold, !cmd.rd_en, $stable(rowa_r) && $stable(rowb_r))
endmodule
`default_nettype wire

// ===== rtl/gain_scheduled_pid_top.sv =====
// Top level of the gain-scheduled PID controller
//
//  channel  | direction | handshake     | carries
//  in_ch    | in        | valid/ready   | kind, setpoint, feedback, sched_value, gains
//  out_ch   | out       | valid/ready   | status, control_out, saturated, active gains
//  cfg_*    | in        | write enable  | register index, write data
//
// One item at a time. A step runs the gain lookup (none for an empty table, else
// a scan of the table intervals) and, in interpolation mode, a bit-serial divide
// and the gain multiplies, then the PID terms on the shared multiplier.
// Synchronous reset clears gains, dynamic state and the point count; table
// contents stay undefined until loaded. A result that is not taken holds the
// next item in its final state until the result register frees.
`default_nettype none
module gain_scheduled_pid_top #(
  parameter int TABLE_POINTS = gsp_pkg::TABLE_POINTS_DEF,
  parameter int FRAC_BITS    = gsp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gsp_in_if.sink                        in_ch,
  gsp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsp_pkg::DATA_W-1:0]    cfg_data
);
  import gsp_pkg::*;

  localparam int AW = $clog2(TABLE_POINTS);

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;

  gsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gsp_ctrl #(.TABLE_POINTS(TABLE_POINTS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .soft_mode (cfg.soft_mode),
    .stat      (stat),
    .cmd       (cmd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr)
  );

  gsp_dp #(.TABLE_POINTS(TABLE_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .wr_addr        (wr_addr),
    .in_kind        (in_ch.kind),
    .in_setpoint    (in_ch.setpoint),
    .in_feedback    (in_ch.feedback),
    .in_sched_value (in_ch.sched_value),
    .in_gain_p      (in_ch.gain_p),
    .in_gain_i      (in_ch.gain_i),
    .in_gain_d      (in_ch.gain_d),
    .out_status     (out_ch.status),
    .out_control    (out_ch.control_out),
    .out_saturated  (out_ch.saturated),
    .out_kp         (out_ch.active_kp),
    .out_ki         (out_ch.active_ki),
    .out_kd         (out_ch.active_kd)
  );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the gain-scheduled PID controller
`timescale 1ns / 1ps
module tb_top;
  import gsp_pkg::*;

  localparam int  CYCLE_LIMIT = 500000;
  localparam int  SETTLE      = 80;
  localparam int  NUM_POINTS  = 8;
  localparam int  QSHIFT      = 16;
  localparam longint ONE_Q    = 65536;

  typedef struct {
    kind_t                    kind;
    logic signed [DATA_W-1:0] sp, fb, sv, gp, gi, gd;
  } pid_item_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] u;
    logic                     sat;
    logic signed [DATA_W-1:0] kp, ki, kd;
  } pid_result_t;

  // Predicts controller results and checks them in order
  class pid_scoreboard;
    longint tbl_pos[NUM_POINTS], tbl_kp[NUM_POINTS], tbl_ki[NUM_POINTS], tbl_kd[NUM_POINTS];
    int     n_points;
    longint acc, last_err, last_fb, dfilt;
    longint gk[3];
    bit     soft_en, dfb;
    longint period, inv_period, omax, omin, ilimit, alpha;
    pid_result_t pending_results[$];
    int     mismatches, checked, steps_seen;

    function new();
      n_points = 0;
      acc = 0; last_err = 0; last_fb = 0; dfilt = 0;
      gk[0] = 0; gk[1] = 0; gk[2] = 0;
      soft_en = 0; dfb = 0;
      period = ONE_Q; inv_period = ONE_Q;
      omax = 0; omin = 0;
      ilimit = 64'h7fff_ffff; alpha = 6554;
      mismatches = 0; checked = 0; steps_seen = 0;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sh7fff_ffff) return 64'sh7fff_ffff;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_SOFT_MODE:  soft_en = d[0];
        REG_DERIV_FB:   dfb = d[0];
        REG_PERIOD:     period = longint'(d[30:0]);
        REG_INV_PERIOD: inv_period = longint'(d[30:0]);
        REG_OUT_MAX:    omax = longint'($signed(d));
        REG_OUT_MIN:    omin = longint'($signed(d));
        REG_INT_LIMIT:  ilimit = longint'(d[30:0]);
        REG_ALPHA:      alpha = longint'(d[16:0]);
        default: ;
      endcase
    endfunction

    function void take_row(int i);
      gk[0] = tbl_kp[i]; gk[1] = tbl_ki[i]; gk[2] = tbl_kd[i];
    endfunction

    // Gain lookup: clamp at table ends, else first interval holding sv
    function void pick_gains(longint sv);
      longint t;
      bit found;
      found = 0;
      if (n_points == 0) begin
        gk[0] = 0; gk[1] = 0; gk[2] = 0;
        return;
      end
      if (sv <= tbl_pos[0]) begin
        take_row(0);
        return;
      end
      if (sv >= tbl_pos[n_points-1]) begin
        take_row(n_points-1);
        return;
      end
      for (int i = 0; i + 1 < n_points; i++) begin
        if (!found && sv >= tbl_pos[i] && sv < tbl_pos[i+1]) begin
          found = 1;
          if (!soft_en) begin
            take_row(i);
          end else begin
            t = ((sv - tbl_pos[i]) <<< QSHIFT) / (tbl_pos[i+1] - tbl_pos[i]);
            gk[0] = tbl_kp[i] + ((t * (tbl_kp[i+1] - tbl_kp[i])) >>> QSHIFT);
            gk[1] = tbl_ki[i] + ((t * (tbl_ki[i+1] - tbl_ki[i])) >>> QSHIFT);
            gk[2] = tbl_kd[i] + ((t * (tbl_kd[i+1] - tbl_kd[i])) >>> QSHIFT);
          end
        end
      end
      if (!found) take_row(n_points-1);
    endfunction

    // Accepted input transfer: work out the expected result
    function void note_item(pid_item_t it);
      pid_result_t r;
      longint sp, fb, err, istep, pterm, iterm, dterm, diff, din, a, u;
      sp = it.sp; fb = it.fb;
      u = 0;
      r.sat = 0;
      if (it.kind == KIND_NONE) return;
      if (it.kind == KIND_LOAD) begin
        if (n_points >= NUM_POINTS) begin
          r.status = ST_FULL;
        end else begin
          tbl_pos[n_points] = it.sv;
          tbl_kp[n_points] = it.gp;
          tbl_ki[n_points] = it.gi;
          tbl_kd[n_points] = it.gd;
          n_points++;
          r.status = ST_STORED;
        end
      end else if (it.kind == KIND_RESET) begin
        acc = 0; last_err = 0; last_fb = 0; dfilt = 0;
        r.status = ST_RESET_DONE;
      end else begin
        steps_seen++;
        pick_gains(it.sv);
        err = clip32(sp - fb);
        pterm = clip32((gk[0] * err) >>> QSHIFT);
        istep = (err * period) >>> QSHIFT;
        acc += istep;
        if (acc > ilimit) acc = ilimit;
        if (acc < -ilimit) acc = -ilimit;
        iterm = clip32((gk[1] * acc) >>> QSHIFT);
        diff = dfb ? -(fb - last_fb) : (err - last_err);
        din = clip32((clip32(diff) * inv_period) >>> QSHIFT);
        a = (alpha > ONE_Q) ? ONE_Q : alpha;
        dfilt = (a * din + (ONE_Q - a) * dfilt) >>> QSHIFT;
        dterm = clip32((gk[2] * dfilt) >>> QSHIFT);
        u = pterm + iterm + dterm;
        if (u > omax) u = omax;
        else if (u < omin) u = omin;
        if (u >= omax || u <= omin) begin
          r.sat = 1;
          acc = clip32(acc - istep);
        end
        last_err = err;
        last_fb = fb;
        r.status = ST_STEP_DONE;
      end
      r.u = u[31:0];
      r.kp = gk[0][31:0];
      r.ki = gk[1][31:0];
      r.kd = gk[2][31:0];
      pending_results.push_back(r);
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH result %0d %s: expected %0d (0x%08h) actual %0d (0x%08h)",
                   checked, name, want, want[31:0], got, got[31:0]);
      end
    endfunction

    // Result transfer: compare against the oldest expectation
    function void check_result(pid_result_t got);
      pid_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected result, status %0d out %0d", got.status, got.u);
        return;
      end
      want = pending_results.pop_front();
      field_check("status", want.status, got.status);
      field_check("control_out", want.u, got.u);
      field_check("saturated", want.sat, got.sat);
      field_check("active_kp", want.kp, got.kp);
      field_check("active_ki", want.ki, got.ki);
      field_check("active_kd", want.kd, got.kd);
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  gsp_in_if  in_ch();
  gsp_out_if out_ch();

  gain_scheduled_pid_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pid_scoreboard sb = new();
  int cycle_cnt = 0;
  int burst_left = 0;
  bit tx_high = 0;
  int n_settings = 0;
  int n_sent = 0;

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, sb.pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: always-ready, random, and fixed stall stretches
  int rx_tick = 0;
  always @(posedge clk) begin
    rx_tick++;
    case ((rx_tick / 700) % 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(1, 0));
      default: out_ch.ready <= ((rx_tick % 11) >= 7);
    endcase
  end

  // Transfer monitors
  always @(posedge clk) begin
    pid_item_t it;
    pid_result_t res;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.kind = kind_t'(in_ch.kind);
      it.sp = in_ch.setpoint; it.fb = in_ch.feedback; it.sv = in_ch.sched_value;
      it.gp = in_ch.gain_p; it.gi = in_ch.gain_i; it.gd = in_ch.gain_d;
      sb.note_item(it);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res.status = status_t'(out_ch.status);
      res.u = out_ch.control_out;
      res.sat = out_ch.saturated;
      res.kp = out_ch.active_kp; res.ki = out_ch.active_ki; res.kd = out_ch.active_kd;
      sb.check_result(res);
    end
  end

  task automatic send_item(input pid_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.setpoint <= it.sp;
    in_ch.feedback <= it.fb;
    in_ch.sched_value <= it.sv;
    in_ch.gain_p <= it.gp;
    in_ch.gain_i <= it.gi;
    in_ch.gain_d <= it.gd;
    tx_high = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    // burst pacing: keep valid up inside a burst, else drop it for a gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      tx_high = 0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 0);
    end
  endtask

  // Hold off until every expected result has come, then let the block settle
  task automatic drain();
    if (tx_high) begin
      in_ch.valid <= 1'b0;
      tx_high = 0;
    end
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic program_regs(input bit soft_en, input bit dfb, input logic [30:0] per,
                              input logic [30:0] inv, input logic [31:0] omax,
                              input logic [31:0] omin, input logic [30:0] lim,
                              input logic [16:0] alpha);
    write_reg(REG_SOFT_MODE, {31'd0, soft_en});
    write_reg(REG_DERIV_FB, {31'd0, dfb});
    write_reg(REG_PERIOD, {1'b0, per});
    write_reg(REG_INV_PERIOD, {1'b0, inv});
    write_reg(REG_OUT_MAX, omax);
    write_reg(REG_OUT_MIN, omin);
    write_reg(REG_INT_LIMIT, {1'b0, lim});
    write_reg(REG_ALPHA, {15'd0, alpha});
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return 32'sh8000_0000;
           1: return 32'sh7fff_ffff;
           2: return 0;
           default: return -1;
         endcase
      2, 3, 4, 5: return $signed($urandom_range(32'h60000, 0)) - 32'sh30000;
      default: return $signed($urandom_range(32'h600000, 0)) - 32'sh300000;
    endcase
  endfunction

  function automatic pid_item_t mk_item(kind_t k, logic signed [31:0] sp,
                                        logic signed [31:0] fb, logic signed [31:0] sv,
                                        logic signed [31:0] gp, logic signed [31:0] gi,
                                        logic signed [31:0] gd);
    pid_item_t it;
    it.kind = k; it.sp = sp; it.fb = fb; it.sv = sv;
    it.gp = gp; it.gi = gi; it.gd = gd;
    return it;
  endfunction

  function automatic pid_item_t rand_item();
    pid_item_t it;
    int r;
    logic signed [31:0] sv;
    r = $urandom_range(99);
    if ($urandom_range(9) < 7) sv = $signed($urandom_range(32'h4A0000, 0)) - 32'sh50000;
    else sv = rand_word();
    it = mk_item(KIND_STEP, rand_word(), rand_word(), sv, $urandom, $urandom, $urandom);
    if (r >= 80) it.kind = KIND_RESET;
    if (r >= 87) it.kind = KIND_LOAD;
    if (r >= 94) it.kind = KIND_NONE;
    return it;
  endfunction

  initial begin
    logic signed [31:0] pos_list[NUM_POINTS];
    logic signed [31:0] omax, omin;
    logic [30:0] per, inv, lim;
    logic [16:0] alpha;
    clk = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.kind = KIND_STEP;
    in_ch.setpoint = 0; in_ch.feedback = 0; in_ch.sched_value = 0;
    in_ch.gain_p = 0; in_ch.gain_i = 0; in_ch.gain_d = 0;
    out_ch.ready = 0;
    // ascending points, with one out-of-order point near the top
    pos_list = '{-32'sh40000, -32'sh10000, 0, 32'sh20000, 32'sh80000, 32'sh10000,
                 32'sh100000, 32'sh400000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table at reset settings, error overflow both ways
    send_item(mk_item(KIND_STEP, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0));
    drain();
    program_regs(1, 0, 31'h10000, 31'h10000, 32'h7fff_ffff, 32'h8000_0000,
                 31'h7fff_ffff, 17'h10000);
    send_item(mk_item(KIND_STEP, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0));

    // table loads, steps on partial tables, then rejects on a full one
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (i == 3)
        send_item(mk_item(KIND_LOAD, 0, 0, pos_list[i], 32'sh7fff_ffff, 32'sh8000_0000,
                          32'sh7fff_ffff));
      else
        send_item(mk_item(KIND_LOAD, 0, 0, pos_list[i],
                          $signed($urandom_range(32'h40000, 0)) - 32'sh8000,
                          $urandom_range(32'h20000, 0), $urandom_range(32'h1000, 0)));
      if (i == 1 || i == 4)
        send_item(mk_item(KIND_STEP, 32'sh18000, 32'sh4000, -32'sh20000, 0, 0, 0));
    end
    send_item(mk_item(KIND_LOAD, 0, 0, 32'sh500000, 1, 2, 3));
    send_item(mk_item(KIND_LOAD, 0, 0, 32'sh8000_0000, -1, -1, -1));

    // scheduling corners: below, on first point, inside, on last, above, unordered span
    send_item(mk_item(KIND_STEP, 32'sh10000, 0, 32'sh8000_0000, 0, 0, 0));
    send_item(mk_item(KIND_STEP, 32'sh10000, 32'sh8000, -32'sh40000, 0, 0, 0));
    send_item(mk_item(KIND_STEP, -32'sh10000, 32'sh8000, 32'sh30000, 0, 0, 0));
    send_item(mk_item(KIND_STEP, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh400000, 0, 0, 0));
    send_item(mk_item(KIND_STEP, 32'sh20000, 32'sh10000, 32'sh7fff_ffff, 0, 0, 0));
    send_item(mk_item(KIND_STEP, 32'sh20000, -32'sh10000, 32'sh90000, 0, 0, 0));
    send_item(mk_item(KIND_RESET, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(KIND_NONE, -1, -1, -1, -1, -1, -1));
    send_item(mk_item(KIND_STEP, 32'sh8000, 0, 32'sh15000, 0, 0, 0));

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      per = 31'($urandom_range(32'h30000, 32'h400));
      inv = 31'($urandom_range(32'h400000, 32'h100));
      lim = 31'($urandom_range(32'h7fff_ffff, 0));
      alpha = 17'($urandom_range(32'h10000, 0));
      omax = $urandom_range(32'h1000000, 32'h1000);
      omin = -$signed($urandom_range(32'h1000000, 32'h1000));
      case (ph)
        1: begin per = 31'd1; inv = 31'h7fff_ffff; alpha = '0; end
        2: begin per = 31'h7fff_ffff; inv = 31'd1; lim = '0; end
        3: begin omax = -32'sh10000; omin = 32'sh10000; end
        4: begin omax = 32'sh7fff_ffff; omin = 32'sh8000_0000; alpha = 17'h1ffff; end
        5: begin lim = 31'h7fff_ffff; alpha = 17'h10000; end
        default: ;
      endcase
      program_regs(ph[0], ph[1] ^ ph[2], per, inv, omax, omin, lim, alpha);
      repeat (92) send_item(rand_item());
    end

    drain();
    $display("Covered %0d input transfers, %0d results checked (%0d control steps)",
             n_sent, sb.checked, sb.steps_seen);
    $display("Register settings used: %0d, mismatches: %0d", n_settings, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== gain_scheduled_pid_top.f =====
+incdir+rtl
rtl/gsp_pkg.sv
rtl/gsp_if.sv
rtl/gsp_cfg.sv
rtl/gsp_ctrl.sv
rtl/gsp_dp.sv
rtl/gain_scheduled_pid_top.sv
tb/tb_top.sv
